// ===== rtl/core/chte_pkg.sv =====
// Shared types and codes of the chained hash table engine.
// No dependencies; chte_front, chte_back and the top level import it.
package chte_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_RANGE     = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    localparam logic CFG_BUCKETS = 1'b0;
    localparam logic CFG_NODES   = 1'b1;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int BUCKET_W = 8;
    localparam int NIDX_W   = 10;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 48;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD,
        BK_WALK,
        BK_POP,
        BK_LINK
    } bk_state_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        cmd_t                cmd;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [BUCKET_W-1:0] bucket;
        logic                bucket_bad;
    } job_t;

endpackage

// ===== rtl/core/chte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/chte_front.sv =====
// Front end: accepts command beats, checks the bucket range and queues them.
// Depends on chte_pkg.
module chte_front
    import chte_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic [8:0]    bucket_limit,
    output logic          q_valid,
    input  logic          q_ready,
    output job_t          q_job
);
    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    job_t       in_job;
    logic       push, pop;

    always_comb begin
        in_job.cmd        = cmd_t'(s_tdata[1:0]);
        in_job.key        = s_tdata[33:2];
        in_job.value      = s_tdata[65:34];
        in_job.bucket     = s_tdata[73:66];
        in_job.bucket_bad = ({1'b0, s_tdata[73:66]} >= bucket_limit);
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_job    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end
endmodule

// ===== rtl/core/chte_back.sv =====
// Back end: walks bucket chains in node memory, manages the free ring and
// holds the result register. Depends on chte_pkg and chte_ram.
module chte_back
    import chte_pkg::*;
#(
    parameter int NODE_COUNT   = 1024,
    parameter int BUCKET_COUNT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [10:0]      nodes_cfg,
    input  logic             q_valid,
    output logic             q_ready,
    input  job_t             q_job,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);
    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [CW-1:0] N_FULL = CW'(NODE_COUNT);
    localparam int RESET_N = (NODE_COUNT < 1024) ? NODE_COUNT : 1024;

    bk_state_t state_reg, state_next;
    job_t      job_reg, job_next;
    logic [NW-1:0] cur_reg, cur_next, prev_reg, prev_next, node_reg, node_next;
    logic          prev_null_reg, prev_null_next;
    logic [CW-1:0] steps_reg, steps_next;

    logic [NW-1:0] fhead_reg, fhead_next, ftail_reg, ftail_next;
    logic [CW-1:0] fcount_reg, fcount_next, pops_reg, pops_next, ninit_reg, ninit_next;
    logic [BUCKET_COUNT-1:0] hvld_reg, hvld_next;

    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [31:0]     out_value_reg, out_value_next;
    logic [NW-1:0]   out_node_reg, out_node_next;

    // Memory ports.
    logic            key_we, val_we, nxt_we, head_we, ring_we;
    logic [NW-1:0]   node_waddr, nxt_waddr, node_raddr;
    logic [NW:0]     nxt_wdata, nxt_rdata;
    logic [31:0]     key_rdata, val_rdata;
    logic [BW-1:0]   head_waddr, head_raddr, job_bidx;
    logic [NW-1:0]   head_wdata, head_rdata, ring_rdata;

    logic [CW-1:0]   n_eff;
    logic [31:0]     b32_q, b32_j, n32, nidx32;
    logic [NW-1:0]   alloc_node;

    assign b32_q      = 32'(q_job.bucket);
    assign b32_j      = 32'(job_reg.bucket);
    assign head_raddr = b32_q[BW-1:0];
    assign job_bidx   = b32_j[BW-1:0];
    assign n32        = (32'(nodes_cfg) < NODE_COUNT) ? 32'(nodes_cfg) : NODE_COUNT;
    assign n_eff      = n32[CW-1:0];
    // The first pops after a clear read the ascending fill that was never stored.
    assign alloc_node = (pops_reg < ninit_reg) ? pops_reg[NW-1:0] : ring_rdata;

    chte_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(node_waddr), .wdata(job_reg.key),
        .raddr(node_raddr), .rdata(key_rdata));
    chte_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(node_waddr), .wdata(job_reg.value),
        .raddr(node_raddr), .rdata(val_rdata));
    chte_ram #(.WIDTH(NW + 1), .DEPTH(NODE_COUNT)) u_nxt_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(node_raddr), .rdata(nxt_rdata));
    chte_ram #(.WIDTH(NW), .DEPTH(BUCKET_COUNT)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    chte_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_ring_ram (
        .aclk(aclk), .we(ring_we), .waddr(ftail_reg), .wdata(cur_reg),
        .raddr(fhead_reg), .rdata(ring_rdata));

    always_comb begin
        state_next      = state_reg;
        job_next        = job_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_null_next  = prev_null_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        fhead_next      = fhead_reg;
        ftail_next      = ftail_reg;
        fcount_next     = fcount_reg;
        pops_next       = pops_reg;
        ninit_next      = ninit_reg;
        hvld_next       = hvld_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_node_next   = out_node_reg;
        q_ready    = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        nxt_we     = 1'b0;
        head_we    = 1'b0;
        ring_we    = 1'b0;
        node_waddr = alloc_node;
        nxt_waddr  = alloc_node;
        nxt_wdata  = {1'b1, {NW{1'b0}}};
        node_raddr = cur_reg;
        head_waddr = job_bidx;
        head_wdata = alloc_node;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_ready         = 1'b1;
                    job_next        = q_job;
                    out_status_next = ST_OK;
                    out_value_next  = '0;
                    out_node_next   = '0;
                    if (q_job.cmd == CMD_CLEAR) begin
                        hvld_next      = '0;
                        fhead_next     = '0;
                        ftail_next     = (n_eff == N_FULL) ? '0 : n_eff[NW-1:0];
                        fcount_next    = n_eff;
                        pops_next      = '0;
                        ninit_next     = n_eff;
                        out_valid_next = 1'b1;
                    end else if (q_job.cmd == CMD_INSERT && fcount_reg == '0) begin
                        out_status_next = ST_FULL;
                        out_valid_next  = 1'b1;
                    end else if (q_job.bucket_bad) begin
                        out_status_next = ST_RANGE;
                        out_valid_next  = 1'b1;
                    end else begin
                        state_next = BK_HEAD;
                    end
                end
            end
            BK_HEAD: begin
                prev_null_next = 1'b1;
                if (!hvld_reg[job_bidx]) begin
                    if (job_reg.cmd == CMD_INSERT) begin
                        state_next = BK_POP;
                    end else begin
                        out_status_next = ST_NOT_FOUND;
                        out_valid_next  = 1'b1;
                        state_next      = BK_IDLE;
                    end
                end else begin
                    node_raddr = head_rdata;
                    cur_next   = head_rdata;
                    steps_next = CW'(1);
                    state_next = BK_WALK;
                end
            end
            BK_WALK: begin
                if (key_rdata == job_reg.key) begin
                    state_next     = BK_IDLE;
                    out_valid_next = 1'b1;
                    if (job_reg.cmd == CMD_INSERT) begin
                        out_status_next = ST_DUPLICATE;
                    end else if (job_reg.cmd == CMD_SEARCH) begin
                        out_value_next = val_rdata;
                        out_node_next  = cur_reg;
                    end else begin
                        out_node_next = cur_reg;
                        if (prev_null_reg) begin
                            head_we             = !nxt_rdata[NW];
                            head_wdata          = nxt_rdata[NW-1:0];
                            hvld_next[job_bidx] = !nxt_rdata[NW];
                        end else begin
                            nxt_we    = 1'b1;
                            nxt_waddr = prev_reg;
                            nxt_wdata = nxt_rdata;
                        end
                        if (fcount_reg < N_FULL) begin
                            ring_we     = 1'b1;
                            ftail_next  = (ftail_reg == NW'(NODE_COUNT - 1)) ? '0
                                                                             : ftail_reg + 1'b1;
                            fcount_next = fcount_reg + 1'b1;
                        end
                    end
                end else begin
                    prev_next      = cur_reg;
                    prev_null_next = 1'b0;
                    if (nxt_rdata[NW] || steps_reg == N_FULL) begin
                        if (job_reg.cmd == CMD_INSERT) begin
                            state_next = BK_POP;
                        end else begin
                            out_status_next = ST_NOT_FOUND;
                            out_valid_next  = 1'b1;
                            state_next      = BK_IDLE;
                        end
                    end else begin
                        node_raddr = nxt_rdata[NW-1:0];
                        cur_next   = nxt_rdata[NW-1:0];
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            BK_POP: begin
                key_we      = 1'b1;
                val_we      = 1'b1;
                nxt_we      = 1'b1;
                node_next   = alloc_node;
                fhead_next  = (fhead_reg == NW'(NODE_COUNT - 1)) ? '0 : fhead_reg + 1'b1;
                fcount_next = fcount_reg - 1'b1;
                pops_next   = (pops_reg == N_FULL) ? pops_reg : pops_reg + 1'b1;
                if (prev_null_reg) begin
                    head_we             = 1'b1;
                    hvld_next[job_bidx] = 1'b1;
                    out_node_next       = alloc_node;
                    out_valid_next      = 1'b1;
                    state_next          = BK_IDLE;
                end else begin
                    state_next = BK_LINK;
                end
            end
            BK_LINK: begin
                nxt_we         = 1'b1;
                nxt_waddr      = prev_reg;
                nxt_wdata      = {1'b0, node_reg};
                out_node_next  = node_reg;
                out_valid_next = 1'b1;
                state_next     = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            hvld_reg      <= '0;
            fhead_reg     <= '0;
            ftail_reg     <= (RESET_N == NODE_COUNT) ? '0 : NW'(RESET_N);
            fcount_reg    <= CW'(RESET_N);
            pops_reg      <= '0;
            ninit_reg     <= CW'(RESET_N);
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hvld_reg      <= hvld_next;
            fhead_reg     <= fhead_next;
            ftail_reg     <= ftail_next;
            fcount_reg    <= fcount_next;
            pops_reg      <= pops_next;
            ninit_reg     <= ninit_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg        <= job_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_null_reg  <= prev_null_next;
        node_reg       <= node_next;
        steps_reg      <= steps_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_node_reg   <= out_node_next;
    end

    assign nidx32   = 32'(out_node_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, nidx32[NIDX_W-1:0], out_value_reg, out_status_reg};
endmodule

// ===== rtl/core/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine: configuration registers,
// front queue and back end. Depends on chte_pkg, chte_front and chte_back.
//
// Usage: commands arrive as beats on the s_ channel; each gives exactly one
// result beat on the m_ channel, in command order. The user must write the
// registers on the cfg_ channel (index 0 buckets in use, 1 nodes in use)
// only while idle; the block itself does not enforce it. m_tvalid is
// registered; clear, full and out-of-range results are set straight from
// the idle state. A search or delete passes through BK_HEAD and then BK_WALK,
// once per chain node visited; an insert that succeeds adds the allocation in
// BK_POP and, when the bucket is not empty, the link in BK_LINK. The chain
// walk is one node memory read per cycle. A two-beat queue sits between the
// front and the back, so commands are still taken while a result waits; the
// back end starts the next command only once m_tready has taken the pending
// result. Reset empties all buckets and fills the free list with ascending
// node indices at once; no clearing pass runs. Clear does the same for the nodes in use.
module chained_hash_table_engine
    import chte_pkg::*;
#(
    parameter int NODE_COUNT   = 1024,
    parameter int BUCKET_COUNT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[1:0], key[33:2], value[65:34], bucket[73:66]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[2:0], found_value[34:3], node_index[44:35]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [10:0]      cfg_data
);
    logic [8:0]  buckets_reg;
    logic [10:0] nodes_reg;
    logic [31:0] limit32;
    logic        q_valid, q_ready;
    job_t        q_job;

    assign cfg_ready = 1'b1;
    assign limit32   = (32'(buckets_reg) < BUCKET_COUNT) ? 32'(buckets_reg) : BUCKET_COUNT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buckets_reg <= 9'd256;
            nodes_reg   <= 11'd1024;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_BUCKETS) begin
                buckets_reg <= cfg_data[8:0];
            end else begin
                nodes_reg <= cfg_data;
            end
        end
    end

    chte_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .bucket_limit(limit32[8:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    chte_back #(.NODE_COUNT(NODE_COUNT), .BUCKET_COUNT(BUCKET_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .nodes_cfg(nodes_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= ST_NOT_FOUND))
        else $error("result status out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != ST_OK) |-> (m_tdata[44:3] == '0))
        else $error("failed command carries a nonzero payload");

    a_value_search_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34:3] != '0) |-> (m_tdata[2:0] == ST_OK))
        else $error("found value on a failed command");
endmodule
